@@ hw/rtl/itoa_pkg.sv @@
// Shared types, command codes, character constants and the control store
// of the integer to ASCII formatter. No dependencies.
package itoa_pkg;

  localparam int MaxCharsDefault = 20;
  localparam int CMD_W           = 3;
  localparam int VALUE_W         = 64;
  localparam int CHAR_W          = 7;
  localparam int DIGIT_W         = 4;
  localparam int PTR_DIGITS      = 16;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_SDEC32 = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SDEC64 = 3'd1;
  localparam logic [CMD_W-1:0] CMD_UDEC32 = 3'd2;
  localparam logic [CMD_W-1:0] CMD_UDEC64 = 3'd3;
  localparam logic [CMD_W-1:0] CMD_HEX32  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_HEX64  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_PTR    = 3'd6;

  // Fixed characters
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2d;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_X     = 7'h78;

  // Microcode fields
  typedef enum logic [1:0] {OP_WAIT, OP_DABBLE, OP_SKIP, OP_EMIT} op_t;
  typedef enum logic [1:0] {CH_MINUS, CH_ZERO, CH_X, CH_DIGIT} chr_t;
  typedef enum logic [2:0] {COND_ALWAYS, COND_DEC, COND_NOT_PTR, COND_NEG, COND_PTR} cond_t;

  typedef logic [2:0] pc_t;

  typedef struct packed {
    op_t   op;
    chr_t  chr;
    cond_t cond;
    pc_t   jump;
  } uword_t;

  // Program step addresses
  localparam pc_t PC_WAIT   = 3'd0;
  localparam pc_t PC_DABBLE = 3'd1;
  localparam pc_t PC_SKIP   = 3'd2;
  localparam pc_t PC_MINUS  = 3'd3;
  localparam pc_t PC_ZERO   = 3'd4;
  localparam pc_t PC_X      = 3'd5;
  localparam pc_t PC_DIGIT  = 3'd6;

  // Datapath control and status
  typedef struct packed {
    logic load;
    logic dabble;
    logic shift;
  } dp_ctl_t;

  typedef struct packed {
    logic               is_dec;
    logic               is_ptr;
    logic               neg;
    logic               loop_end;
    logic               top_zero;
    logic               one_left;
    logic [DIGIT_W-1:0] top_digit;
  } dp_stat_t;

  // Control store: one word per step, skipped when its condition is false
  function automatic uword_t ucode(input pc_t pc);
    uword_t w;
    w = '{op: OP_WAIT, chr: CH_DIGIT, cond: COND_ALWAYS, jump: PC_WAIT};
    unique case (pc)
      PC_WAIT:   w = '{op: OP_WAIT,   chr: CH_DIGIT, cond: COND_ALWAYS,  jump: PC_WAIT};
      PC_DABBLE: w = '{op: OP_DABBLE, chr: CH_DIGIT, cond: COND_DEC,     jump: PC_WAIT};
      PC_SKIP:   w = '{op: OP_SKIP,   chr: CH_DIGIT, cond: COND_NOT_PTR, jump: PC_WAIT};
      PC_MINUS:  w = '{op: OP_EMIT,   chr: CH_MINUS, cond: COND_NEG,     jump: PC_WAIT};
      PC_ZERO:   w = '{op: OP_EMIT,   chr: CH_ZERO,  cond: COND_PTR,     jump: PC_WAIT};
      PC_X:      w = '{op: OP_EMIT,   chr: CH_X,     cond: COND_PTR,     jump: PC_WAIT};
      PC_DIGIT:  w = '{op: OP_EMIT,   chr: CH_DIGIT, cond: COND_ALWAYS,  jump: PC_WAIT};
      default:   w = '{op: OP_WAIT,   chr: CH_DIGIT, cond: COND_ALWAYS,  jump: PC_WAIT};
    endcase
    return w;
  endfunction

  // Digit to character, table "0123456789abcdef"
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    unique case (d)
      4'h0: c = 7'h30;
      4'h1: c = 7'h31;
      4'h2: c = 7'h32;
      4'h3: c = 7'h33;
      4'h4: c = 7'h34;
      4'h5: c = 7'h35;
      4'h6: c = 7'h36;
      4'h7: c = 7'h37;
      4'h8: c = 7'h38;
      4'h9: c = 7'h39;
      4'ha: c = 7'h61;
      4'hb: c = 7'h62;
      4'hc: c = 7'h63;
      4'hd: c = 7'h64;
      4'he: c = 7'h65;
      default: c = 7'h66;
    endcase
    return c;
  endfunction

endpackage

@@ hw/rtl/itoa_if.sv @@
// Valid/ready channel interfaces for the formatter's request and result.
// Depends on itoa_pkg for field widths.
interface itoa_req_if;
  import itoa_pkg::*;
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [VALUE_W-1:0] value;
  modport source (output valid, command, value, input ready);
  modport sink   (input valid, command, value, output ready);
endinterface

interface itoa_res_if;
  import itoa_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              last_char;
  modport source (output valid, char_code, last_char, input ready);
  modport sink   (input valid, char_code, last_char, output ready);
endinterface

@@ hw/rtl/itoa_dp.sv @@
// Formatter datapath: magnitude register, shift-add-3 decimal converter and
// digit buffer. Depends on itoa_pkg.
module itoa_dp #(
  parameter int MAX_CHARS = itoa_pkg::MaxCharsDefault
) (
  input  logic                       clk,
  input  itoa_pkg::dp_ctl_t          ctl,
  input  logic [itoa_pkg::CMD_W-1:0] command,
  input  logic [itoa_pkg::VALUE_W-1:0] value,
  output itoa_pkg::dp_stat_t         stat
);
  import itoa_pkg::*;

  localparam int DIG_W  = MAX_CHARS * DIGIT_W;
  localparam int LEFT_W = $clog2(MAX_CHARS + 1);
  localparam int CNT_W  = $clog2(VALUE_W + 1);
  localparam int HALF_W = VALUE_W / 2;

  logic [DIG_W-1:0]   digits, digits_next;
  logic [VALUE_W-1:0] mag, mag_next;
  logic [CNT_W-1:0]   cnt, cnt_next;
  logic [LEFT_W-1:0]  left, left_next;
  logic               is_dec, is_dec_next;
  logic               is_ptr, is_ptr_next;
  logic               neg, neg_next;

  logic [HALF_W-1:0]  low_mag;
  logic [VALUE_W-1:0] full_mag;
  logic [DIG_W-1:0]   adjusted;

  // Two's complement magnitudes for the signed modes
  assign low_mag  = value[HALF_W-1] ? (~value[HALF_W-1:0] + 1'b1) : value[HALF_W-1:0];
  assign full_mag = value[VALUE_W-1] ? (~value + 1'b1) : value;

  // Add 3 to every BCD digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < MAX_CHARS; i++) begin
      adjusted[i*DIGIT_W +: DIGIT_W] =
        (digits[i*DIGIT_W +: DIGIT_W] >= 4'd5) ?
        digits[i*DIGIT_W +: DIGIT_W] + 4'd3 : digits[i*DIGIT_W +: DIGIT_W];
    end
  end

  // Load, convert or shift out
  always_comb begin
    digits_next = digits;
    mag_next    = mag;
    cnt_next    = cnt;
    left_next   = left;
    is_dec_next = is_dec;
    is_ptr_next = is_ptr;
    neg_next    = neg;
    if (ctl.load) begin
      digits_next = '0;
      mag_next    = value;
      cnt_next    = CNT_W'(VALUE_W);
      left_next   = LEFT_W'(MAX_CHARS);
      is_dec_next = 1'b1;
      is_ptr_next = 1'b0;
      neg_next    = 1'b0;
      unique case (command)
        CMD_SDEC32: begin
          neg_next = value[HALF_W-1];
          mag_next = {low_mag, {HALF_W{1'b0}}};
          cnt_next = CNT_W'(HALF_W);
        end
        CMD_SDEC64: begin
          neg_next = value[VALUE_W-1];
          mag_next = full_mag;
        end
        CMD_UDEC32: begin
          mag_next = {value[HALF_W-1:0], {HALF_W{1'b0}}};
          cnt_next = CNT_W'(HALF_W);
        end
        CMD_UDEC64: begin
          mag_next = value;
        end
        CMD_HEX32: begin
          is_dec_next = 1'b0;
          digits_next = DIG_W'(value[HALF_W-1:0]);
        end
        CMD_HEX64: begin
          is_dec_next = 1'b0;
          digits_next = DIG_W'(value);
        end
        default: begin
          is_dec_next = 1'b0;
          is_ptr_next = 1'b1;
          digits_next = {value, {(DIG_W-VALUE_W){1'b0}}};
          left_next   = LEFT_W'(PTR_DIGITS);
        end
      endcase
    end else if (ctl.dabble) begin
      digits_next = {adjusted[DIG_W-2:0], mag[VALUE_W-1]};
      mag_next    = {mag[VALUE_W-2:0], 1'b0};
      cnt_next    = cnt - 1'b1;
    end else if (ctl.shift) begin
      digits_next = {digits[DIG_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
      left_next   = left - 1'b1;
    end
  end

  // Hold datapath registers
  always_ff @(posedge clk) begin
    digits <= digits_next;
    mag    <= mag_next;
    cnt    <= cnt_next;
    left   <= left_next;
    is_dec <= is_dec_next;
    is_ptr <= is_ptr_next;
    neg    <= neg_next;
  end

  // Status to the sequencer
  assign stat.is_dec    = is_dec;
  assign stat.is_ptr    = is_ptr;
  assign stat.neg       = neg;
  assign stat.loop_end  = (cnt == CNT_W'(1));
  assign stat.top_digit = digits[DIG_W-1 -: DIGIT_W];
  assign stat.top_zero  = (digits[DIG_W-1 -: DIGIT_W] == '0);
  assign stat.one_left  = (left == LEFT_W'(1));

endmodule

@@ hw/rtl/integer_to_ascii_formatter.sv @@
// Integer to ASCII formatter top level: microcoded sequencer and result register.
// Depends on itoa_pkg, itoa_if and itoa_dp.
// Per item: accept, shift-add-3 conversion for the decimal modes, leading zero skip except for pointer,
// then a minus sign if negative or a 0x prefix for pointer, then the digits.
// One item at a time; an output stall holds the emit step until the result register is free.
// Reset returns the program counter to the wait step and empties the result register.
module integer_to_ascii_formatter #(
  parameter int MAX_CHARS = itoa_pkg::MaxCharsDefault
) (
  input logic        clk,
  input logic        rst,
  itoa_req_if.sink   request,
  itoa_res_if.source result
);
  import itoa_pkg::*;

  pc_t               pc, pc_next;
  uword_t            uw;
  logic              cond_ok;
  logic              slot_free;
  logic              out_load;
  dp_ctl_t           ctl;
  dp_stat_t          stat;
  logic              out_valid, out_valid_next;
  logic [CHAR_W-1:0] out_char, out_char_next;
  logic              out_last, out_last_next;

  itoa_dp #(.MAX_CHARS(MAX_CHARS)) u_dp (
    .clk     (clk),
    .ctl     (ctl),
    .command (request.command),
    .value   (request.value),
    .stat    (stat)
  );

  assign uw        = ucode(pc);
  assign slot_free = !out_valid || result.ready;

  // Evaluate the step condition
  always_comb begin
    unique case (uw.cond)
      COND_ALWAYS:  cond_ok = 1'b1;
      COND_DEC:     cond_ok = stat.is_dec;
      COND_NOT_PTR: cond_ok = !stat.is_ptr;
      COND_NEG:     cond_ok = stat.neg;
      COND_PTR:     cond_ok = stat.is_ptr;
      default:      cond_ok = 1'b0;
    endcase
  end

  // Execute the control word: advance, hold or jump
  always_comb begin
    pc_next       = pc;
    ctl           = '0;
    request.ready = 1'b0;
    out_load      = 1'b0;
    if (!cond_ok) begin
      pc_next = pc + 3'd1;
    end else begin
      unique case (uw.op)
        OP_WAIT: begin
          request.ready = 1'b1;
          // unused command code: take the transaction and drop it
          if (request.valid && request.command <= CMD_PTR) begin
            ctl.load = 1'b1;
            pc_next  = pc + 3'd1;
          end
        end
        OP_DABBLE: begin
          ctl.dabble = 1'b1;
          if (stat.loop_end) begin
            pc_next = pc + 3'd1;
          end
        end
        OP_SKIP: begin
          if (stat.top_zero && !stat.one_left) begin
            ctl.shift = 1'b1;
          end else begin
            pc_next = pc + 3'd1;
          end
        end
        default: begin
          if (slot_free) begin
            out_load = 1'b1;
            if (uw.chr == CH_DIGIT) begin
              ctl.shift = 1'b1;
              if (stat.one_left) begin
                pc_next = uw.jump;
              end
            end else begin
              pc_next = pc + 3'd1;
            end
          end
        end
      endcase
    end
  end

  // Select the character and fill the result register
  always_comb begin
    out_char_next  = out_char;
    out_last_next  = out_last;
    out_valid_next = out_valid && !result.ready;
    if (out_load) begin
      out_valid_next = 1'b1;
      out_last_next  = (uw.chr == CH_DIGIT) && stat.one_left;
      unique case (uw.chr)
        CH_MINUS: out_char_next = CHAR_MINUS;
        CH_ZERO:  out_char_next = CHAR_ZERO;
        CH_X:     out_char_next = CHAR_X;
        default:  out_char_next = digit_char(stat.top_digit);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= PC_WAIT;
      out_valid <= 1'b0;
    end else begin
      pc        <= pc_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    out_char <= out_char_next;
    out_last <= out_last_next;
  end

  assign result.valid     = out_valid;
  assign result.char_code = out_char;
  assign result.last_char = out_last;

endmodule
